### hw/rtl/pal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// shared types, codes and defaults for the positional array list
// ----------------------------------------------------------------------------
package pal_pkg;

    // default sizes
    localparam int PAL_CAPACITY    = 16;
    localparam int PAL_VALUE_WIDTH = 32;

    // fixed field widths
    localparam int POS_W   = 4;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    // operation codes
    localparam logic [1:0] MODE_INSERT   = 2'd0;
    localparam logic [1:0] MODE_REMOVE   = 2'd1;
    localparam logic [1:0] MODE_RETRIEVE = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    // read value of a failed retrieve
    localparam logic signed [DATA_W-1:0] READ_BAD = -32'sd1;

    typedef struct packed {
        logic [1:0]               mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic                     is_full;
    } out_word_t;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
    } dp_cmd_t;

endpackage

### hw/rtl/pal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ctrl
// handshake controller: accepts a word, tracks the held result
// ----------------------------------------------------------------------------
module pal_ctrl
    import pal_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (accept)
                    state_next = S_HOLD;
                else if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_HOLD:
            begin
                out_valid = 1'b1;
                // result register frees up as it drains
                in_ready  = out_ready;
            end
            default: ;
        endcase
        cmd.exec = in_valid && in_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hw/rtl/pal_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_datapath
// row of shifting cells, entry count and result register
// ----------------------------------------------------------------------------
module pal_datapath
    import pal_pkg::*;
#(
    parameter int CAPACITY    = PAL_CAPACITY,
    parameter int VALUE_WIDTH = PAL_VALUE_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_cmd_t   cmd,
    input  in_word_t  in_word,
    output out_word_t out_word
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    logic [VALUE_WIDTH-1:0] cells_reg  [CAPACITY];
    logic [VALUE_WIDTH-1:0] cells_next [CAPACITY];
    logic [VALUE_WIDTH-1:0] prev_cell  [CAPACITY];
    logic [VALUE_WIDTH-1:0] succ_cell  [CAPACITY];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    out_word_t              result_reg;
    out_word_t              result_next;

    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic                   do_ins;
    logic                   do_rem;
    logic                   rd_good;
    logic                   rd_bad;
    logic [1:0]             status;
    logic [VALUE_WIDTH-1:0] wr_word;
    logic [VALUE_WIDTH-1:0] rd_word;
    logic [DATA_W-1:0]      rd_data;

    assign pos_ext = CMP_W'(in_word.position);
    assign cnt_ext = CMP_W'(count_reg);

    // operation decode and checks
    always_comb
    begin
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        rd_good = 1'b0;
        rd_bad  = 1'b0;
        status  = STAT_OK;
        unique case (in_word.mode)
            MODE_INSERT:
            begin
                if (count_reg == CNT_W'(CAPACITY))
                    status = STAT_FULL;
                else if (pos_ext > cnt_ext)
                    status = STAT_RANGE;
                else
                    do_ins = 1'b1;
            end
            MODE_REMOVE:
            begin
                if (count_reg == '0)
                    status = STAT_EMPTY;
                else if (pos_ext >= cnt_ext)
                    status = STAT_RANGE;
                else
                    do_rem = 1'b1;
            end
            MODE_RETRIEVE:
            begin
                if (count_reg == '0)
                begin
                    status = STAT_EMPTY;
                    rd_bad = 1'b1;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    status = STAT_RANGE;
                    rd_bad = 1'b1;
                end
                else
                    rd_good = 1'b1;
            end
            default: ;
        endcase
    end

    // value width adaptation on the way in and out
    generate
        if (VALUE_WIDTH >= DATA_W)
        begin : g_wide
            assign wr_word = VALUE_WIDTH'(in_word.value);
            assign rd_data = rd_word[DATA_W-1:0];
        end
        else
        begin : g_narrow
            assign wr_word = in_word.value[VALUE_WIDTH-1:0];
            assign rd_data = DATA_W'(rd_word);
        end
    endgenerate

    // read mux over the addressable cells
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (in_word.position == POS_W'(i))
                rd_word = cells_reg[i];
        end
    end

    // each cell picks its neighbor, the new word, or holds
    generate
        for (genvar g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g > 0)
            begin : g_prev
                assign prev_cell[g] = cells_reg[g-1];
            end
            else
            begin : g_head
                assign prev_cell[g] = cells_reg[g];
            end
            if (g < CAPACITY - 1)
            begin : g_succ
                assign succ_cell[g] = cells_reg[g+1];
            end
            else
            begin : g_tail
                assign succ_cell[g] = cells_reg[g];
            end

            always_comb
            begin
                cells_next[g] = cells_reg[g];
                if (do_ins)
                begin
                    if (CMP_W'(g) == pos_ext)
                        cells_next[g] = wr_word;
                    else if (CMP_W'(g) > pos_ext)
                        cells_next[g] = prev_cell[g];
                end
                else if (do_rem && (CMP_W'(g) >= pos_ext))
                    cells_next[g] = succ_cell[g];
            end

            always_ff @(posedge clk)
            begin
                if (cmd.exec)
                    cells_reg[g] <= cells_next[g];
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + 1'b1;
        else if (do_rem)
            count_next = count_reg - 1'b1;

        result_next.read_value  = rd_good ? rd_data : (rd_bad ? READ_BAD : '0);
        result_next.status      = status;
        result_next.entry_count = COUNT_W'(count_next);
        result_next.is_empty    = (count_next == '0);
        result_next.is_full     = (count_next == CNT_W'(CAPACITY));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
            result_reg <= result_next;
    end

    assign out_word = result_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> result_reg.entry_count == COUNT_W'(count_reg))
        else $error("reported count differs from held count");

    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && status != STAT_OK) |=> $stable(count_reg))
        else $error("failed operation changed the count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && do_ins) |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("insert did not grow the list by one");
`endif

endmodule

### hw/rtl/positional_array_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list
// bounded ordered list with insert, remove and retrieve at a position
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              word
//  in        sink       in_valid / in_ready    in_word  (mode, position, value)
//  out       source     out_valid / out_ready  out_word (read_value, status,
//                                                        entry_count, flags)
//
//  each word is executed in the cycle it is accepted: all cells shift or hold
//  in parallel, and the result is loaded into the output register at the
//  accepting edge and offered from the next cycle
//  a new word is taken every cycle while out_ready is high; a stalled result
//  blocks input only until it is taken
//  reset clears the entry count and drops any held result; cell contents stay
//  undefined until written and are never read before that
//
module positional_array_list
    import pal_pkg::*;
#(
    parameter int CAPACITY    = PAL_CAPACITY,
    parameter int VALUE_WIDTH = PAL_VALUE_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    // execute strobe from the controller to the datapath
    dp_cmd_t cmd;

    // handshake control and result tracking
    pal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // list storage, checks and result register
    pal_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_word  (in_word),
        .out_word (out_word)
    );

endmodule
